// ===== rtl/c2e_pkg.sv =====
// Package for the calendar to epoch time converter.
// Holds shared constants, the month offset table and the controller command type.
// No dependencies.
package c2e_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned MilliW  = 10;
  localparam int unsigned OutW    = 49;
  localparam int unsigned DaysW   = 24;
  localparam int unsigned SecsW   = 41;
  localparam int unsigned LeapW   = 13;

  localparam int unsigned Recip100   = 5243;
  localparam int unsigned Recip100Sh = 19;
  localparam int unsigned EpochYear  = 1970;
  localparam int unsigned LeapsBeforeEpoch = 478;
  localparam longint unsigned AltEpochMs = 64'd47313240000;

  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic CfgAddrEpochSel = 1'b0;

  typedef struct packed {
    logic load;
    logic en_div;
    logic en_days;
    logic en_secs;
    logic en_ms;
  } c2e_cmd_t;

  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/c2e_ctrl.sv =====
// Controller for the calendar to epoch time converter.
// Sequences the datapath through its four steps and raises the result strobe.
// Depends on c2e_pkg.
module c2e_ctrl import c2e_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  output c2e_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StDays,
    StSecs,
    StMs
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start) begin
            state_q <= StDiv;
          end
        end
        StDiv:  state_q <= StDays;
        StDays: state_q <= StSecs;
        StSecs: state_q <= StMs;
        StMs: begin
          state_q <= StIdle;
          done_q  <= 1'b1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy          = (state_q != StIdle);
  assign done_o        = done_q;
  assign cmd_o.load    = start && (state_q == StIdle);
  assign cmd_o.en_div  = (state_q == StDiv);
  assign cmd_o.en_days = (state_q == StDays);
  assign cmd_o.en_secs = (state_q == StSecs);
  assign cmd_o.en_ms   = (state_q == StMs);

endmodule

// ===== rtl/c2e_datapath.sv =====
// Datapath for the calendar to epoch time converter.
// Leap counts, day count, seconds and milliseconds, one registered step each.
// Depends on c2e_pkg.
module c2e_datapath import c2e_pkg::*; (
  input  logic                      clk_i,
  input  c2e_cmd_t                  cmd_i,
  input  logic                      epoch_sel_i,
  input  logic [YearW-1:0]          year_value_i,
  input  logic [MonthW-1:0]         month_value_i,
  input  logic [DayW-1:0]           day_value_i,
  input  logic [HourW-1:0]          hour_value_i,
  input  logic [MinuteW-1:0]        minute_value_i,
  input  logic [SecondW-1:0]        second_value_i,
  input  logic [MilliW-1:0]         milli_value_i,
  output logic signed [OutW-1:0]    epoch_ms_o,
  output logic                      bad_month_o
);

  logic [YearW-1:0]   year_q;
  logic [MonthW-1:0]  month_q;
  logic [DayW-1:0]    day_q;
  logic [HourW-1:0]   hour_q;
  logic [MinuteW-1:0] minute_q;
  logic [SecondW-1:0] second_q;
  logic [MilliW-1:0]  milli_q;
  logic               sel_q;
  logic               bad_q;

  logic [LeapW-1:0]        leaps_q, leaps_d;
  logic [7:0]              cy100_q, cy100_d;
  logic signed [DaysW-1:0] days_q, days_d;
  logic signed [SecsW-1:0] secs_q, secs_d;
  logic signed [OutW-1:0]  ms_q, ms_d;
  logic                    bad_out_q;

  // Step one: leap years before the given year, and the year divided by 100.
  logic [YearW-1:0] prev_year;
  logic [YearW-3:0] prev_q4;
  logic [26:0]      prod_p100;
  logic [24:0]      prod_p400;
  logic [26:0]      prod_y100;
  logic [7:0]       p100;
  logic [5:0]       p400;

  always_comb begin
    prev_year = year_q - YearW'(1);
    prev_q4   = prev_year[YearW-1:2];
    prod_p100 = 27'(prev_year) * 27'(Recip100);
    prod_p400 = 25'(prev_q4) * 25'(Recip100);
    prod_y100 = 27'(year_q) * 27'(Recip100);
    p100      = prod_p100[Recip100Sh +: 8];
    p400      = prod_p400[Recip100Sh +: 6];
    cy100_d   = prod_y100[Recip100Sh +: 8];
    if (year_q == '0) begin
      leaps_d = '0;
    end else begin
      leaps_d = LeapW'(prev_q4) - LeapW'(p100) + LeapW'(p400) + LeapW'(1);
    end
  end

  // Step two: day count relative to the epoch year.
  logic [YearW-1:0]        hundreds;
  logic                    cent;
  logic                    is_leap;
  logic signed [DaysW-1:0] yr_off;
  logic signed [DaysW-1:0] extra;

  always_comb begin
    hundreds = YearW'(14'(cy100_q) * 14'd100);
    cent     = (hundreds == year_q);
    is_leap  = ((year_q[1:0] == 2'b00) && !cent) || (cent && (cy100_q[1:0] == 2'b00));
    yr_off   = $signed(DaysW'(year_q)) - $signed(DaysW'(EpochYear));
    extra    = (is_leap && (month_q > MonthFeb)) ? DaysW'(1) : '0;
    days_d   = DaysW'(yr_off * $signed(DaysW'(365)))
             + $signed(DaysW'(leaps_q))
             - $signed(DaysW'(LeapsBeforeEpoch))
             + $signed(DaysW'(days_before_month(month_q)))
             + extra
             + $signed(DaysW'(day_q))
             - $signed(DaysW'(1));
  end

  // Step three: seconds.
  always_comb begin
    secs_d = SecsW'($signed({{(SecsW-DaysW){days_q[DaysW-1]}}, days_q})
                    * $signed(SecsW'(86400)))
           + $signed(SecsW'(SecsW'(hour_q) * SecsW'(3600)))
           + $signed(SecsW'(SecsW'(minute_q) * SecsW'(60)))
           + $signed(SecsW'(second_q));
  end

  // Step four: milliseconds and epoch offset.
  always_comb begin
    ms_d = OutW'($signed({{(OutW-SecsW){secs_q[SecsW-1]}}, secs_q})
                 * $signed(OutW'(1000)))
         + $signed(OutW'(milli_q));
    if (sel_q) begin
      ms_d = ms_d - $signed(OutW'(AltEpochMs));
    end
    if (bad_q) begin
      ms_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      year_q   <= year_value_i;
      month_q  <= month_value_i;
      day_q    <= day_value_i;
      hour_q   <= hour_value_i;
      minute_q <= minute_value_i;
      second_q <= second_value_i;
      milli_q  <= milli_value_i;
      sel_q    <= epoch_sel_i;
      bad_q    <= (month_value_i == '0) || (month_value_i > MonthDec);
    end
    if (cmd_i.en_div) begin
      leaps_q <= leaps_d;
      cy100_q <= cy100_d;
    end
    if (cmd_i.en_days) begin
      days_q <= days_d;
    end
    if (cmd_i.en_secs) begin
      secs_q <= secs_d;
    end
    if (cmd_i.en_ms) begin
      ms_q      <= ms_d;
      bad_out_q <= bad_q;
    end
  end

  assign epoch_ms_o  = ms_q;
  assign bad_month_o = bad_out_q;

endmodule

// ===== rtl/calendar_to_epoch_time.sv =====
// Calendar to epoch time converter, top level with the configuration register.
// The result strobe done_o follows the start transfer through the states StDiv,
// StDays, StSecs and StMs; a new start is taken only back in StIdle.
// busy is high in the four datapath steps; the receiver cannot stall results.
// Reset clears the controller and sets epoch_select to zero (Unix epoch).
// Depends on c2e_pkg, c2e_ctrl and c2e_datapath.
module calendar_to_epoch_time import c2e_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic                   paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic [YearW-1:0]       year_value_i,
  input  logic [MonthW-1:0]      month_value_i,
  input  logic [DayW-1:0]        day_value_i,
  input  logic [HourW-1:0]       hour_value_i,
  input  logic [MinuteW-1:0]     minute_value_i,
  input  logic [SecondW-1:0]     second_value_i,
  input  logic [MilliW-1:0]      milli_value_i,
  output logic                   done_o,
  output logic signed [OutW-1:0] epoch_ms_o,
  output logic                   bad_month_o
);

  logic     epoch_sel_q;
  c2e_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_sel_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == CfgAddrEpochSel)) begin
      epoch_sel_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == CfgAddrEpochSel) ? {31'b0, epoch_sel_q} : '0;

  c2e_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  c2e_datapath u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .epoch_sel_i    (epoch_sel_q),
    .year_value_i   (year_value_i),
    .month_value_i  (month_value_i),
    .day_value_i    (day_value_i),
    .hour_value_i   (hour_value_i),
    .minute_value_i (minute_value_i),
    .second_value_i (second_value_i),
    .milli_value_i  (milli_value_i),
    .epoch_ms_o     (epoch_ms_o),
    .bad_month_o    (bad_month_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start transfer did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_month_o) |-> (epoch_ms_o == '0)) else $error("bad month with nonzero result");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(busy)) else $error("result strobe without conversion");

endmodule
